### hw/rtl/cxc_pkg.sv
package cxc_pkg;

  // fixed result field widths
  localparam int LAG_BITS = 6;
  localparam int SUM_BITS = 38;

  // result tdata: lag_index, correlation_sum, zero pad to whole bytes
  localparam int OUT_W = ((LAG_BITS + SUM_BITS + 7) / 8) * 8;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;    // zero the accumulator at the start of a lag
    logic rd_valid; // ram read data is a live operand pair this cycle
  } mac_ctl_t;

endpackage

### hw/rtl/cxc_ram.sv
module cxc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/cxc_mac.sv
module cxc_mac #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cxc_pkg::mac_ctl_t             ctl,
  input  logic signed [SAMPLE_BITS-1:0] a_data,
  input  logic signed [SAMPLE_BITS-1:0] b_data,
  output logic                          busy,
  output logic [cxc_pkg::SUM_BITS-1:0]  sum
);
  import cxc_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int ACC_W  = (PROD_W > SUM_BITS) ? PROD_W : SUM_BITS;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  prod_ext;

  // sign extend the product; the sum wraps modulo 2^SUM_BITS
  assign prod_ext = ACC_W'(prod);

  // multiply stage
  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.rd_valid;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod_ext;
    end
  end

  assign busy = prod_valid;
  assign sum  = acc[SUM_BITS-1:0];

endmodule

### hw/rtl/circular_cross_correlator_core.sv
// circular cross-correlator: pairs (a, b) stream in on the slave side, one
// pair per item, until an item with tlast set or until MAX_LENGTH pairs are
// in, which closes the run as if tlast were set. For a run of n pairs the
// block then sends n result items, lag j = 0 .. n-1, each carrying the exact
// sum over i of a[i] * b[(i + j) mod n], with tlast on lag n-1. Each lag is
// one pass of the single shared multiply-accumulate unit over the two sample
// rams (one read per ram per cycle), then a drain in which the read and
// multiply registers empty and the last product is added, then the handoff
// of the sum to the output register, which waits while that register holds
// a result not yet taken. s_tready is low while the lags are computed; a
// result waiting in the output register does not keep the next run from
// loading.
module circular_cross_correlator_core #(
  parameter int MAX_LENGTH  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // slave side: sample pairs
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, lowest bit up: sample_a, sample_b, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  input  logic                          s_tlast,  // last_sample
  // master side: correlation results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, lowest bit up: lag_index, correlation_sum, zero pad
  output logic [cxc_pkg::OUT_W-1:0]     m_tdata,
  output logic                          m_tlast   // last_result
);
  import cxc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LENGTH);

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,  // taking pairs
    S_RUN   = 4'b0010,  // issuing ram reads for one lag
    S_DRAIN = 4'b0100,  // waiting for the mac pipeline to empty
    S_HOLD  = 4'b1000   // handing the finished sum to the output register
  } state_t;

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] count;     // pairs loaded so far in this run
  logic [ADDR_W-1:0] last_idx;  // n - 1 of the run being computed
  logic [ADDR_W-1:0] lag;
  logic [ADDR_W-1:0] idx_a;     // i
  logic [ADDR_W-1:0] idx_b;     // (i + lag) mod n
  logic              rd_valid;
  logic              clear;

  logic signed [SAMPLE_BITS-1:0] in_a;
  logic signed [SAMPLE_BITS-1:0] in_b;
  logic signed [SAMPLE_BITS-1:0] rd_a;
  logic signed [SAMPLE_BITS-1:0] rd_b;

  mac_ctl_t          mac_ctl;
  logic              mac_busy;
  logic [SUM_BITS-1:0] mac_sum;

  logic              out_valid;
  logic [LAG_BITS-1:0] out_lag;
  logic [SUM_BITS-1:0] out_sum;
  logic              out_last;

  logic in_fire;
  logic run_end;
  logic issue_last;
  logic out_free;
  logic lag_last;

  assign in_a = s_tdata[SAMPLE_BITS-1:0];
  assign in_b = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  assign s_tready   = (state == S_LOAD);
  assign in_fire    = s_tvalid && s_tready;
  assign run_end    = s_tlast || (count == ADDR_W'(MAX_LENGTH - 1));
  assign issue_last = (idx_a == last_idx);
  assign out_free   = !out_valid || m_tready;
  assign lag_last   = (lag == last_idx);

  // sample stores: written while loading, read once per mac step
  cxc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LENGTH)
  ) u_ram_a (
    .clk   (clk),
    .we    (in_fire),
    .waddr (count),
    .wdata (in_a),
    .raddr (idx_a),
    .rdata (rd_a)
  );

  cxc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_LENGTH)
  ) u_ram_b (
    .clk   (clk),
    .we    (in_fire),
    .waddr (count),
    .wdata (in_b),
    .raddr (idx_b),
    .rdata (rd_b)
  );

  assign mac_ctl.clear    = clear;
  assign mac_ctl.rd_valid = rd_valid;

  cxc_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .a_data (rd_a),
    .b_data (rd_b),
    .busy   (mac_busy),
    .sum    (mac_sum)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_fire && run_end) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // ram read and product registers both empty: sum is final
        if (!rd_valid && !mac_busy) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = lag_last ? S_LOAD : S_RUN;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // pair counter and run length
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= run_end ? '0 : count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && run_end) begin
      last_idx <= count;
    end
  end

  // lag and read address walk
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      lag   <= '0;
      idx_a <= '0;
      idx_b <= '0;
    end else if (state == S_RUN) begin
      idx_a <= idx_a + 1'b1;
      idx_b <= (idx_b == last_idx) ? '0 : idx_b + 1'b1;
    end else if (state == S_HOLD && out_free && !lag_last) begin
      lag   <= lag + 1'b1;
      idx_a <= '0;
      idx_b <= lag + 1'b1;
    end
  end

  // read data is live in the cycle after an issue
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_RUN);
    end
  end

  // clear the accumulator in the cycle of each lag's first issue
  always_ff @(posedge clk) begin
    if (rst) begin
      clear <= 1'b1;
    end else begin
      clear <= (state_next == S_RUN) && (state != S_RUN);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HOLD && out_free) begin
      out_lag  <= LAG_BITS'(lag);
      out_sum  <= mac_sum;
      out_last <= lag_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(OUT_W - LAG_BITS - SUM_BITS){1'b0}}, out_sum, out_lag};

endmodule

### tb/circular_cross_correlator_core_tb.sv
`timescale 1ns / 1ps

module circular_cross_correlator_core_tb;
  import cxc_pkg::*;

  localparam int MAX_LEN     = 64;
  localparam int SAMPLE_W    = 16;
  localparam int IN_W        = ((2*SAMPLE_W+7)/8)*8;
  localparam int HOLD_CYCLES = 600;   // long receiver hold-off, fills the block
  localparam int QUIET_LIMIT = 5000;  // cycles with no item moving on either side
  localparam int RAND_PAIRS  = 40;

  typedef struct {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic                       last;
  } pair_t;

  typedef struct {
    logic [LAG_BITS-1:0] lag;
    logic [SUM_BITS-1:0] sum;
    logic                last;
  } corr_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            s_tlast = 1'b0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic            m_tlast;

  pair_t pending_pairs[$];
  corr_t expected_corr[$];

  // predictor copy of the sample stores
  logic signed [SAMPLE_W-1:0] a_store [MAX_LEN];
  logic signed [SAMPLE_W-1:0] b_store [MAX_LEN];
  int run_len = 0;

  int total_pairs = 0;
  int pairs_sent = 0;
  int runs_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatch_cnt = 0;
  int send_idle;
  int recv_idle;

  circular_cross_correlator_core #(
    .MAX_LENGTH (MAX_LEN),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // idle rates follow progress through the stimulus
  always_comb begin
    if (pairs_sent < total_pairs / 3) begin
      send_idle = 11;
      recv_idle = 74;
    end else if (pairs_sent < 2 * total_pairs / 3) begin
      send_idle = 74;
      recv_idle = 11;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  // store one pair; on the end of a run, compute every circular lag
  task automatic accumulate_pair(input pair_t p);
    longint acc;
    corr_t r;
    a_store[run_len] = p.a;
    b_store[run_len] = p.b;
    run_len++;
    if (p.last || run_len == MAX_LEN) begin
      for (int j = 0; j < run_len; j++) begin
        acc = 0;
        for (int i = 0; i < run_len; i++)
          acc += longint'(a_store[i]) * longint'(b_store[(i + j) % run_len]);
        r.lag  = LAG_BITS'(j);
        r.sum  = SUM_BITS'(acc);
        r.last = (j == run_len - 1);
        expected_corr.push_back(r);
      end
      run_len = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatch_cnt++;
  endtask

  task automatic check_result();
    corr_t want;
    if (expected_corr.size() == 0) begin
      report_mismatch("unexpected result item", '0, 64'(m_tdata));
      return;
    end
    want = expected_corr.pop_front();
    if (m_tdata[LAG_BITS-1:0] != want.lag)
      report_mismatch("lag_index", 64'(want.lag), 64'(m_tdata[LAG_BITS-1:0]));
    if (m_tdata[LAG_BITS +: SUM_BITS] != want.sum)
      report_mismatch("correlation_sum", 64'(want.sum), 64'(m_tdata[LAG_BITS +: SUM_BITS]));
    if (m_tlast != want.last)
      report_mismatch("last_result", 64'(want.last), 64'(m_tlast));
  endtask

  // sender: presents the head of the pending queue, holds it until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tlast    <= 1'b0;
      pairs_sent <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        accumulate_pair(pending_pairs.pop_front());
        pairs_sent <= pairs_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= IN_W'({pending_pairs[0].b, pending_pairs[0].a});
          s_tlast  <= pending_pairs[0].last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result item, stalls at random, and twice holds
  // off for a long stretch right after a run completes
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      runs_done <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
        if (m_tlast)
          runs_done <= runs_done + 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (m_tvalid && m_tready && m_tlast && (runs_done == 2 || runs_done == 6)) begin
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // extremes weighted heavily, otherwise any 16-bit value
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic add_pair(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                          input logic last);
    pair_t p;
    p.a = a;
    p.b = b;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  task automatic add_run(input int len);
    for (int i = 0; i < len; i++)
      add_pair(pick_sample(), pick_sample(), i == len - 1);
  endtask

  initial begin
    int rand_cnt;
    int len;
    bit full_done;

    // single pair runs at the extremes
    add_pair(16'h8000, 16'h8000, 1'b1);
    add_pair(16'h7fff, 16'h8000, 1'b1);
    add_pair(16'h0000, 16'h0000, 1'b1);
    // two pairs, largest positive products
    add_pair(16'h8000, 16'h8000, 1'b0);
    add_pair(16'h8000, 16'h8000, 1'b1);
    // three pairs, mixed signs, lag order shows up in the sums
    add_pair(16'h7fff, 16'hffff, 1'b0);
    add_pair(16'h8000, 16'h0001, 1'b0);
    add_pair(16'h0001, 16'h8000, 1'b1);
    // alternating bit patterns
    for (int i = 0; i < 8; i++)
      add_pair((i % 2) ? 16'haaaa : 16'h5555, 16'h0001 << (2 * i), i == 7);

    rand_cnt = 0;
    full_done = 0;
    while (rand_cnt < RAND_PAIRS) begin
      if (!full_done && rand_cnt >= RAND_PAIRS / 2) begin
        // full run: the 64th pair closes it, with or without tlast
        for (int i = 0; i < MAX_LEN; i++)
          add_pair(pick_sample(), pick_sample(), (i == MAX_LEN - 1) && $urandom_range(1));
        full_done = 1;
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      add_run(len);
      rand_cnt += len;
    end
    total_pairs = pending_pairs.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || expected_corr.size() != 0)
      @(posedge clk);
    // let any stray result show up
    repeat (200) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### circular_cross_correlator_core.f
hw/rtl/cxc_pkg.sv
hw/rtl/cxc_ram.sv
hw/rtl/cxc_mac.sv
hw/rtl/circular_cross_correlator_core.sv
tb/circular_cross_correlator_core_tb.sv
